// File: sv/mixer_iir_filter_unit_defines.svh
// assertion macros used by the mixer iir filter controller
`ifndef MIXER_IIR_FILTER_UNIT_DEFINES_SVH
`define MIXER_IIR_FILTER_UNIT_DEFINES_SVH

// same-cycle implication on clk_i, disabled while rst_ni is low
`define MIF_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, disabled while rst_ni is low
`define MIF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/mif_pkg.sv
// types, constants and helper functions of the mixer iir filter
`timescale 1ns / 1ps
`default_nettype none

package mif_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int DAC_W      = 12;
  localparam int COEF_W     = 24;
  localparam int STATE_W    = 32;
  localparam int ACC_W      = 64;
  localparam int PROD_W     = COEF_W + STATE_W;
  localparam int NUM_COEFS  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int STEP_W     = 4;

  localparam int MIX_OFFSET = 1 << 11;
  localparam int MIX_SHIFT  = 11;
  localparam int DAC_MAX    = (1 << 12) - 1;

  localparam int STATE_FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC_BITS_DEF  = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    COEF_B0 = 3'd0,
    COEF_B2 = 3'd1,
    COEF_B4 = 3'd2,
    COEF_A1 = 3'd3,
    COEF_A2 = 3'd4,
    COEF_A3 = 3'd5,
    COEF_A4 = 3'd6
  } coef_idx_e;

  localparam logic signed [COEF_W-1:0] COEF_RESET [NUM_COEFS] = '{
    24'sd1049, -24'sd2097, 24'sd1049, 24'sd3319792,
    -24'sd4632609, 24'sd3175088, -24'sd959447
  };

  typedef enum logic [2:0] {
    MUL_MIX,
    MUL_B2,
    MUL_B4,
    MUL_A1,
    MUL_A2,
    MUL_A3,
    MUL_A4,
    MUL_B0
  } mul_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_ROUND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic     load_in;
    mul_sel_e mul_sel;
    logic     x_load;
    logic     acc_clr;
    logic     acc_add;
    logic     y_load;
    logic     commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) begin
      sat32 = hi[STATE_W-1:0];
    end else if (v < lo) begin
      sat32 = lo[STATE_W-1:0];
    end else begin
      sat32 = v[STATE_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// File: sv/mif_ctrl.sv
// controller state machine sequencing the shared multiplier and accumulator
`timescale 1ns / 1ps
`default_nettype none
`include "mixer_iir_filter_unit_defines.svh"

module mif_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   s_tvalid_i,
  output logic                  s_tready_o,
  input  mif_pkg::dp_status_t   status_i,
  output mif_pkg::ctrl_cmd_t    cmd_o
);
  import mif_pkg::*;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(8);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              s_xfer;
  logic              calc_first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) state_d = ST_CALC;
      end
      ST_CALC: begin
        if (step_q == LastStep) begin
          state_d = ST_ROUND;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_ROUND: state_d = ST_FINISH;
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o    = 1'b1;
        cmd_o.load_in = s_tvalid_i;
      end
      ST_CALC: begin
        case (step_q)
          STEP_W'(0): cmd_o.mul_sel = MUL_MIX;
          STEP_W'(1): begin
            cmd_o.mul_sel = MUL_B2;
            cmd_o.x_load  = 1'b1;
            cmd_o.acc_clr = 1'b1;
          end
          STEP_W'(2): begin
            cmd_o.mul_sel = MUL_B4;
            cmd_o.acc_add = 1'b1;
          end
          STEP_W'(3): begin
            cmd_o.mul_sel = MUL_A1;
            cmd_o.acc_add = 1'b1;
          end
          STEP_W'(4): begin
            cmd_o.mul_sel = MUL_A2;
            cmd_o.acc_add = 1'b1;
          end
          STEP_W'(5): begin
            cmd_o.mul_sel = MUL_A3;
            cmd_o.acc_add = 1'b1;
          end
          STEP_W'(6): begin
            cmd_o.mul_sel = MUL_A4;
            cmd_o.acc_add = 1'b1;
          end
          STEP_W'(7): begin
            cmd_o.mul_sel = MUL_B0;
            cmd_o.acc_add = 1'b1;
          end
          default: begin
            cmd_o.mul_sel = MUL_MIX;
            cmd_o.acc_add = 1'b1;
          end
        endcase
      end
      ST_ROUND:  cmd_o.y_load = 1'b1;
      ST_FINISH: cmd_o.commit = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

  assign s_xfer     = s_tvalid_i && s_tready_o;
  assign calc_first = (state_q == ST_CALC) && (step_q == '0);

  `MIF_ASSERT_IMPL(a_commit_needs_room, cmd_o.commit, status_i.out_free, "commit while output full")
  `MIF_ASSERT_NEXT(a_accept_starts_calc, s_xfer, calc_first, "transfer did not start calc")
  `MIF_ASSERT_IMPL(a_step_in_range, state_q == ST_CALC, step_q <= LastStep, "step counter overran")

endmodule

`default_nettype wire

// File: sv/mif_datapath.sv
// datapath: coefficients, histories, shared multiplier, accumulator, output register
`timescale 1ns / 1ps
`default_nettype none

module mif_datapath #(
  parameter int STATE_FRAC_BITS = mif_pkg::STATE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = mif_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  mif_pkg::ctrl_cmd_t                   cmd_i,
  output mif_pkg::dp_status_t                  status_o,
  input  wire [mif_pkg::IN_TDATA_W-1:0]        s_tdata_i,
  input  wire                                  cfg_we_i,
  input  wire [mif_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  wire [mif_pkg::COEF_W-1:0]            cfg_data_i,
  input  wire                                  m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [mif_pkg::OUT_TDATA_W-1:0]      m_tdata_o
);
  import mif_pkg::*;

  localparam int MixW  = SAMPLE_W + 1;
  localparam int MixUp = (STATE_FRAC_BITS >= MIX_SHIFT) ? STATE_FRAC_BITS - MIX_SHIFT : 0;
  localparam int MixDn = (STATE_FRAC_BITS >= MIX_SHIFT) ? 0 : MIX_SHIFT - STATE_FRAC_BITS;
  localparam int IntW  = STATE_W - STATE_FRAC_BITS + 1;
  localparam int SumW  = IntW + 2;
  localparam logic signed [ACC_W-1:0] RoundHalf = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic        [ACC_W-1:0] MixMask   = (ACC_W'(1) << MixDn) - ACC_W'(1);
  localparam logic signed [SumW-1:0]  DacOffset = SumW'(MIX_OFFSET);
  localparam logic signed [SumW-1:0]  DacMaxS   = SumW'(DAC_MAX);

  logic signed [COEF_W-1:0]  coef_q   [NUM_COEFS];
  logic signed [STATE_W-1:0] x_hist_q [4];
  logic signed [STATE_W-1:0] y_hist_q [4];
  logic [1:0]                pos_q;
  logic [SAMPLE_W-1:0]       sample_a_q, sample_b_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [STATE_W-1:0] x_q, y_q;
  logic                      out_valid_q;
  logic [DAC_W-1:0]          dac_q;

  logic [1:0]                pos_m1, pos_m2, pos_m3;
  logic signed [MixW-1:0]    da, db;
  logic signed [COEF_W-1:0]  op_a;
  logic signed [STATE_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   mix_p, mix_scaled, mix_shifted, mix_val;
  logic signed [STATE_W-1:0] x_d, y_d;
  logic signed [ACC_W-1:0]   rnd_sum, rnd_shift;
  logic signed [IntW-1:0]    y_int;
  logic signed [SumW-1:0]    dac_sum;
  logic [DAC_W-1:0]          dac_d;

  assign pos_m1 = pos_q - 2'd1;
  assign pos_m2 = pos_q - 2'd2;
  assign pos_m3 = pos_q - 2'd3;

  assign da = $signed({1'b0, sample_a_q}) - MixW'(MIX_OFFSET);
  assign db = $signed({1'b0, sample_b_q}) - MixW'(MIX_OFFSET);

  // shared multiplier operand select
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd_i.mul_sel)
      MUL_MIX: begin
        op_a = {{(COEF_W-MixW){da[MixW-1]}}, da};
        op_b = {{(STATE_W-MixW){db[MixW-1]}}, db};
      end
      MUL_B2: begin
        op_a = coef_q[COEF_B2];
        op_b = x_hist_q[pos_m2];
      end
      MUL_B4: begin
        op_a = coef_q[COEF_B4];
        op_b = x_hist_q[pos_q];
      end
      MUL_A1: begin
        op_a = coef_q[COEF_A1];
        op_b = y_hist_q[pos_m1];
      end
      MUL_A2: begin
        op_a = coef_q[COEF_A2];
        op_b = y_hist_q[pos_m2];
      end
      MUL_A3: begin
        op_a = coef_q[COEF_A3];
        op_b = y_hist_q[pos_m3];
      end
      MUL_A4: begin
        op_a = coef_q[COEF_A4];
        op_b = y_hist_q[pos_q];
      end
      MUL_B0: begin
        op_a = coef_q[COEF_B0];
        op_b = x_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // mixer scaling to the state format, truncating toward zero
  always_comb begin
    mix_p       = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    mix_scaled  = mix_p <<< MixUp;
    mix_shifted = mix_scaled >>> MixDn;
    mix_val     = mix_shifted;
    if (mix_p[ACC_W-1] && ((mix_p & MixMask) != '0)) begin
      mix_val = mix_shifted + ACC_W'(1);
    end
    x_d = sat32(mix_val);
  end

  // round half up to the state format
  always_comb begin
    rnd_sum   = acc_q + RoundHalf;
    rnd_shift = rnd_sum >>> COEF_FRAC_BITS;
    y_d       = sat32(rnd_shift);
  end

  // integer part toward zero, offset and clamp
  always_comb begin
    y_int = IntW'(y_q >>> STATE_FRAC_BITS);
    if (y_q[STATE_W-1] && (y_q[STATE_FRAC_BITS-1:0] != '0)) begin
      y_int = y_int + IntW'(1);
    end
    dac_sum = SumW'(y_int) + DacOffset;
    if (dac_sum < 0) begin
      dac_d = '0;
    end else if (dac_sum > DacMaxS) begin
      dac_d = DAC_W'(DAC_MAX);
    end else begin
      dac_d = dac_sum[DAC_W-1:0];
    end
  end

  // configuration and history state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_COEFS; i++) coef_q[i] <= COEF_RESET[i];
      for (int i = 0; i < 4; i++) begin
        x_hist_q[i] <= '0;
        y_hist_q[i] <= '0;
      end
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_COEFS))) begin
        coef_q[cfg_idx_i] <= cfg_data_i;
      end
      if (cmd_i.commit) begin
        x_hist_q[pos_q] <= x_q;
        y_hist_q[pos_q] <= y_q;
        pos_q           <= pos_q + 2'd1;
        out_valid_q     <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      sample_a_q <= s_tdata_i[SAMPLE_W-1:0];
      sample_b_q <= s_tdata_i[2*SAMPLE_W-1:SAMPLE_W];
    end
    prod_q <= prod;
    if (cmd_i.x_load) x_q <= x_d;
    if (cmd_i.acc_clr) begin
      acc_q <= '0;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
    if (cmd_i.y_load) y_q <= y_d;
    if (cmd_i.commit) dac_q <= dac_d;
  end

  assign status_o.out_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o        = out_valid_q;
  assign m_tdata_o         = {{(OUT_TDATA_W-DAC_W){1'b0}}, dac_q};

endmodule

`default_nettype wire

// File: sv/mixer_iir_filter_unit.sv
// result: the dac value enters the output register at commit, which waits while the output is full
// a new sample pair is taken only in the idle state, once the last one is through; the single shared
// 24x32 multiplier forms the mixer product and the seven filter products in turn
// reset: coefficients take their default values, x and y histories and the
// ring position clear at once, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module mixer_iir_filter_unit #(
  parameter int STATE_FRAC_BITS = mif_pkg::STATE_FRAC_BITS_DEF,
  parameter int COEF_FRAC_BITS  = mif_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire [mif_pkg::IN_TDATA_W-1:0]    s_axis_tdata,   // sample_a, sample_b
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [mif_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,   // dac_value, zero pad
  input  wire                              cfg_we_i,
  input  wire [mif_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire [mif_pkg::COEF_W-1:0]        cfg_data_i
);
  import mif_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  mif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mif_datapath #(
    .STATE_FRAC_BITS (STATE_FRAC_BITS),
    .COEF_FRAC_BITS  (COEF_FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_axis_tdata),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// testbench for mixer_iir_filter_unit: streams sample pairs and checks dac values
`timescale 1ns / 1ps

module tb;
  import mif_pkg::*;

  localparam int STATE_FRAC   = STATE_FRAC_BITS_DEF;
  localparam int COEF_FRAC    = COEF_FRAC_BITS_DEF;
  localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
  localparam int SAMPLE_MID   = MIX_OFFSET;
  localparam int QUIET_CYCLES = 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 204;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_NONE = 3'd7;
  localparam logic [COEF_W-1:0] COEF_MAX = 24'h7fffff;
  localparam logic [COEF_W-1:0] COEF_MIN = 24'h800000;
  localparam logic [COEF_W-1:0] COEF_ONE = 24'h100000;

  localparam longint STATE_MAX = 64'sd2147483647;
  localparam longint STATE_MIN = -64'sd2147483648;

  typedef enum int {
    IDLE_SRC_LIGHT,
    IDLE_SRC_HEAVY,
    IDLE_OFF
  } idle_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // sample_a, sample_b
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;        // dac_value, zero pad
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_idx_i = '0;
  logic [COEF_W-1:0]      cfg_data_i = '0;

  // filter state as the block should hold it
  logic signed [COEF_W-1:0]  coef_q [NUM_COEFS];
  logic signed [STATE_W-1:0] x_hist [4];
  logic signed [STATE_W-1:0] y_hist [4];
  logic [1:0]                ring_pos;

  logic [IN_TDATA_W-1:0] sample_pairs_q [$];
  logic [DAC_W-1:0]      dac_expect_q [$];
  int                    pairs_in_flight = 0;
  idle_mode_e            idle_mode = IDLE_SRC_LIGHT;
  int                    mismatch_count = 0;
  int                    stall_cycles = 0;

  mixer_iir_filter_unit #(
    .STATE_FRAC_BITS(STATE_FRAC),
    .COEF_FRAC_BITS (COEF_FRAC)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic logic signed [STATE_W-1:0] clip_state(input longint v);
    longint c;
    c = v;
    if (c > STATE_MAX) begin
      c = STATE_MAX;
    end else if (c < STATE_MIN) begin
      c = STATE_MIN;
    end
    return c[STATE_W-1:0];
  endfunction

  // mixes one pair, runs the filter and advances the histories
  function automatic logic [DAC_W-1:0] predict_dac(input logic [IN_TDATA_W-1:0] pair);
    longint                    da;
    longint                    db;
    longint                    acc;
    longint                    yr;
    longint                    dac;
    logic signed [STATE_W-1:0] xn;
    logic signed [STATE_W-1:0] yn;
    logic [1:0]                p1;
    logic [1:0]                p2;
    logic [1:0]                p3;
    da = longint'(pair[SAMPLE_W-1:0]) - MIX_OFFSET;
    db = longint'(pair[2*SAMPLE_W-1:SAMPLE_W]) - MIX_OFFSET;
    xn = clip_state((da * db) <<< (STATE_FRAC - MIX_SHIFT));
    p1 = ring_pos - 2'd1;
    p2 = ring_pos - 2'd2;
    p3 = ring_pos - 2'd3;
    acc = longint'(coef_q[COEF_B0]) * longint'(xn)
        + longint'(coef_q[COEF_B2]) * longint'(x_hist[p2])
        + longint'(coef_q[COEF_B4]) * longint'(x_hist[ring_pos])
        + longint'(coef_q[COEF_A1]) * longint'(y_hist[p1])
        + longint'(coef_q[COEF_A2]) * longint'(y_hist[p2])
        + longint'(coef_q[COEF_A3]) * longint'(y_hist[p3])
        + longint'(coef_q[COEF_A4]) * longint'(y_hist[ring_pos]);
    // round half up, then floor
    yr = (acc + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
    yn = clip_state(yr);
    dac = longint'(yn) / (longint'(1) <<< STATE_FRAC) + MIX_OFFSET;
    if (dac < 0) begin
      dac = 0;
    end else if (dac > DAC_MAX) begin
      dac = DAC_MAX;
    end
    x_hist[ring_pos] = xn;
    y_hist[ring_pos] = yn;
    ring_pos = ring_pos + 2'd1;
    return dac[DAC_W-1:0];
  endfunction

  function automatic bit sender_pause();
    int pct;
    case (idle_mode)
      IDLE_SRC_LIGHT: pct = 16;
      IDLE_SRC_HEAVY: pct = 84;
      default:        pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit receiver_pause();
    int pct;
    case (idle_mode)
      IDLE_SRC_LIGHT: pct = 84;
      IDLE_SRC_HEAVY: pct = 16;
      default:        pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SAMPLE_W'(SAMPLE_MAX);
      2:       return SAMPLE_W'(SAMPLE_MID - 4 + $urandom_range(0, 8));
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef(input int span);
    return COEF_W'($urandom_range(0, 2 * span) - span);
  endfunction

  task automatic push_pair(input int a, input int b);
    sample_pairs_q.push_back({SAMPLE_W'(b), SAMPLE_W'(a)});
    pairs_in_flight++;
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx < CFG_IDX_W'(NUM_COEFS)) begin
      coef_q[idx] = value;
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] vals [NUM_COEFS]);
    write_coef(CFG_IDX_NONE, COEF_W'($urandom));
    for (int i = 0; i < NUM_COEFS; i++) begin
      write_coef(CFG_IDX_W'(i), vals[i]);
    end
  endtask

  task automatic wait_quiet();
    while (pairs_in_flight != 0 || dac_expect_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // sample pair driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        dac_expect_q.push_back(predict_dac(s_axis_tdata));
        pairs_in_flight--;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_pairs_q.size() != 0 && !sender_pause()) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= sample_pairs_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // dac value monitor
  always @(posedge clk_i) begin : dac_check
    logic [DAC_W-1:0] want;
    m_axis_tready <= !receiver_pause();
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (dac_expect_q.size() == 0) begin
        $error("dac_value: unexpected transfer, actual %0d", m_axis_tdata[DAC_W-1:0]);
        mismatch_count++;
      end else begin
        want = dac_expect_q.pop_front();
        if (m_axis_tdata[DAC_W-1:0] !== want) begin
          $error("dac_value mismatch: expected %0d, actual %0d",
                 want, m_axis_tdata[DAC_W-1:0]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("mixer_iir_filter_unit verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [COEF_W-1:0] vals [NUM_COEFS];
    for (int i = 0; i < NUM_COEFS; i++) begin
      coef_q[i] = COEF_RESET[i];
    end
    for (int i = 0; i < 4; i++) begin
      x_hist[i] = '0;
      y_hist[i] = '0;
    end
    ring_pos = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default coefficients, sample extremes
    push_pair(SAMPLE_MID, SAMPLE_MID);
    push_pair(0, 0);
    push_pair(0, SAMPLE_MAX);
    push_pair(SAMPLE_MAX, 0);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(SAMPLE_MID, 0);
    push_pair(0, SAMPLE_MID);
    push_pair(SAMPLE_MAX, SAMPLE_MID);
    push_pair(SAMPLE_MID - 1, SAMPLE_MID + 1);
    push_pair(1, SAMPLE_MAX - 1);
    wait_quiet();

    // unit gain: output follows the mixer, upper clamp
    for (int i = 0; i < NUM_COEFS; i++) begin
      vals[i] = '0;
    end
    vals[COEF_B0] = COEF_ONE;
    load_coefs(vals);
    push_pair(0, 0);
    push_pair(0, SAMPLE_MAX);
    push_pair(SAMPLE_MID, SAMPLE_MID);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    push_pair(1, SAMPLE_MID - 1);
    wait_quiet();

    // largest coefficients, saturation of y
    for (int i = 0; i < NUM_COEFS; i++) begin
      vals[i] = COEF_MAX;
    end
    load_coefs(vals);
    push_pair(0, 0);
    push_pair(SAMPLE_MAX, 0);
    push_pair(0, SAMPLE_MAX);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    wait_quiet();

    for (int i = 0; i < NUM_COEFS; i++) begin
      vals[i] = COEF_MIN;
    end
    load_coefs(vals);
    push_pair(0, 0);
    push_pair(SAMPLE_MAX, 0);
    push_pair(SAMPLE_MID, SAMPLE_MID);
    push_pair(SAMPLE_MAX, SAMPLE_MAX);
    wait_quiet();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 3) begin
        idle_mode = IDLE_SRC_LIGHT;
      end else if (ph < 6) begin
        idle_mode = IDLE_SRC_HEAVY;
      end else begin
        idle_mode = IDLE_OFF;
      end
      case (ph % 4)
        0: begin
          for (int i = 0; i < NUM_COEFS; i++) begin
            vals[i] = COEF_RESET[i];
          end
        end
        1: begin
          // feedforward only
          for (int i = 0; i < NUM_COEFS; i++) begin
            vals[i] = '0;
          end
          vals[COEF_B0] = COEF_W'($urandom_range(1 << 19, 1 << 21));
          vals[COEF_B2] = rand_coef(1 << 19);
          vals[COEF_B4] = rand_coef(1 << 19);
        end
        2: begin
          for (int i = 0; i < NUM_COEFS; i++) begin
            vals[i] = COEF_W'($urandom);
          end
        end
        default: begin
          vals[COEF_B0] = COEF_W'($urandom);
          vals[COEF_B2] = COEF_W'($urandom);
          vals[COEF_B4] = COEF_W'($urandom);
          vals[COEF_A1] = rand_coef(1 << 20);
          vals[COEF_A2] = rand_coef(1 << 18);
          vals[COEF_A3] = rand_coef(1 << 18);
          vals[COEF_A4] = rand_coef(1 << 18);
        end
      endcase
      load_coefs(vals);
      repeat (PHASE_ITEMS) push_pair(int'(rand_sample()), int'(rand_sample()));
      wait_quiet();
    end

    if (mismatch_count == 0) begin
      $display("mixer_iir_filter_unit verification clean");
    end else begin
      $display("mixer_iir_filter_unit verification failed");
    end
    $finish;
  end

endmodule
